[hw/rtl/iso_date_string_validator_macros.svh]
// assertion macros for the iso date string validator checker
// used by iso_dv_checker; needs clk and rst_n in the scope of use
`ifndef ISO_DATE_STRING_VALIDATOR_MACROS_SVH
`define ISO_DATE_STRING_VALIDATOR_MACROS_SVH

// same-cycle implication, held off during reset
`define ISO_DV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define ISO_DV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/iso_dv_pkg.sv]
// shared types, constants and helper functions for the iso date validator
// no dependencies; imported by iso_dv_check and iso_date_string_validator
package iso_dv_pkg;

  typedef logic [3:0] digit_t;
  typedef logic [3:0] pos_t;

  // byte positions and character codes of the YYYY-MM-DD pattern
  localparam pos_t       DATE_LEN    = 4'd10;
  localparam pos_t       POS_SAT     = 4'd11;
  localparam pos_t       POS_HYPHEN1 = 4'd4;
  localparam pos_t       POS_HYPHEN2 = 4'd7;
  localparam logic [7:0] CH_HYPHEN   = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [13:0] YEAR_MIN   = 14'd1970;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;

  // collected digits and status of one string
  typedef struct packed {
    digit_t year3;
    digit_t year2;
    digit_t year1;
    digit_t year0;
    digit_t month1;
    digit_t month0;
    digit_t day1;
    digit_t day0;
    pos_t   position;
    logic   format_good;
  } date_fields_t;

  // two decimal digits tens:ones form a multiple of four
  function automatic logic bcd_pair_mod4(input digit_t tens, input digit_t ones);
    logic even_tens;
    even_tens = ~tens[0];
    return (even_tens && (ones == 4'd0 || ones == 4'd4 || ones == 4'd8)) ||
           (!even_tens && (ones == 4'd2 || ones == 4'd6));
  endfunction

  // days in month 1..12, zero for anything else
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

[hw/rtl/iso_date_string_validator.sv]
// top level of the iso date string validator: input register, per-byte
// parse state and result register; uses iso_dv_pkg and iso_dv_check
//
// Takes a date string one byte per item, last byte flagged, and gives one
// result item on the last byte: date_valid is 1 when the string is exactly
// YYYY-MM-DD and names a real date from 1970-01-01 to 9999-12-31. One item
// is taken every cycle while input ready is high; an item passes through
// the input register, and the result of a last byte is then registered in
// the output register. Input ready drops only while a result waits in the
// output register and the sink is not ready.
module iso_date_string_validator
  import iso_dv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_byte,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_date_valid
);

  logic         in_valid_r, in_valid_nxt;
  logic [7:0]   in_byte_r;
  logic         in_last_r;
  date_fields_t fields_r, fields_nxt;
  date_fields_t fields_upd;
  logic         out_valid_r, out_valid_nxt;
  logic         out_date_r, out_date_nxt;
  logic         out_free;
  logic         proc_go;
  logic         is_digit;
  logic         date_ok;
  digit_t       digit;

  // handshake
  assign out_free = !out_valid_r || out_ready;
  assign proc_go  = in_valid_r && out_free;
  assign in_ready = !in_valid_r || out_free;

  // input register
  assign in_valid_nxt = in_ready ? in_valid : in_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_char_byte;
      in_last_r <= in_is_last;
    end
  end

  // classify the byte
  assign is_digit = (in_byte_r >= CH_ZERO) && (in_byte_r <= CH_NINE);
  assign digit    = 4'(in_byte_r - CH_ZERO);

  // fields after this byte
  always_comb begin
    fields_upd = fields_r;
    if (fields_r.position >= DATE_LEN) begin
      fields_upd.format_good = 1'b0;
    end else if (fields_r.position == POS_HYPHEN1 || fields_r.position == POS_HYPHEN2) begin
      if (in_byte_r != CH_HYPHEN) fields_upd.format_good = 1'b0;
    end else if (!is_digit) begin
      fields_upd.format_good = 1'b0;
    end else begin
      unique case (fields_r.position)
        4'd0:    fields_upd.year3  = digit;
        4'd1:    fields_upd.year2  = digit;
        4'd2:    fields_upd.year1  = digit;
        4'd3:    fields_upd.year0  = digit;
        4'd5:    fields_upd.month1 = digit;
        4'd6:    fields_upd.month0 = digit;
        4'd8:    fields_upd.day1   = digit;
        4'd9:    fields_upd.day0   = digit;
        default: fields_upd.format_good = fields_r.format_good;
      endcase
    end
    if (fields_r.position != POS_SAT) fields_upd.position = fields_r.position + 4'd1;
  end

  iso_dv_check u_check (
    .fields  (fields_upd),
    .date_ok (date_ok)
  );

  // parse state: advance per item, clear after the last byte
  always_comb begin
    fields_nxt = fields_r;
    if (proc_go) begin
      if (in_last_r) begin
        fields_nxt             = '0;
        fields_nxt.format_good = 1'b1;
      end else begin
        fields_nxt = fields_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fields_r             <= '0;
      fields_r.format_good <= 1'b1;
    end else begin
      fields_r <= fields_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_date_nxt  = out_date_r;
    if (out_free) begin
      out_valid_nxt = proc_go && in_last_r;
      out_date_nxt  = date_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_date_r <= out_date_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_date_valid = out_date_r;

endmodule

[hw/rtl/iso_dv_check.sv]
// calendar check of one complete string: format, length, year range,
// month range and day against month length; uses iso_dv_pkg
module iso_dv_check
  import iso_dv_pkg::*;
(
  input  date_fields_t fields,
  output logic         date_ok
);

  logic [13:0] year_num;
  logic [6:0]  month_num;
  logic [6:0]  day_num;
  logic        century;
  logic        leap;
  logic        year_in;
  logic        month_in;
  logic [4:0]  month_len;

  // digit values to binary, constant weights only
  assign year_num  = 14'(fields.year3 * 14'd1000) + 14'(fields.year2 * 14'd100) +
                     14'(fields.year1 * 14'd10) + 14'(fields.year0);
  assign month_num = 7'(fields.month1 * 7'd10) + 7'(fields.month0);
  assign day_num   = 7'(fields.day1 * 7'd10) + 7'(fields.day0);

  // gregorian leap rule on the decimal digits
  assign century = (fields.year1 == 4'd0) && (fields.year0 == 4'd0);
  assign leap    = century ? bcd_pair_mod4(fields.year3, fields.year2)
                           : bcd_pair_mod4(fields.year1, fields.year0);

  // range checks
  assign year_in   = (year_num >= YEAR_MIN) && (year_num <= YEAR_MAX);
  assign month_in  = (month_num >= 7'd1) && (month_num <= 7'd12);
  assign month_len = month_days(month_num[3:0], leap);

  assign date_ok = fields.format_good && (fields.position == DATE_LEN) &&
                   year_in && month_in && (day_num >= 7'd1) &&
                   (day_num <= {2'b00, month_len});

endmodule

[hw/rtl/iso_dv_checker.sv]
// port-level checker for iso_date_string_validator, bound to the top level
// uses the macros in iso_date_string_validator_macros.svh
`include "iso_date_string_validator_macros.svh"

module iso_dv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_char_byte,
  input logic       in_is_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_date_valid
);

  // a stalled result holds
  `ISO_DV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_date_valid), "stalled result changed")

  // input stalls only behind a stalled result
  `ISO_DV_ASSERT_NOW(a_in_stall, !in_ready, out_valid && !out_ready, "input stalled without output stall")

  // a fresh result follows an accepted last byte, via the input and result registers
  `ISO_DV_ASSERT_NOW(a_out_cause, $rose(out_valid), $past(in_valid && in_ready && in_is_last, 2), "result without last byte")

endmodule

bind iso_date_string_validator iso_dv_checker u_iso_dv_checker (.*);

[tb/tb.sv]
// self-checking testbench for iso_date_string_validator: date strings go in one byte per item
// and each verdict is checked against a local model of the date parser
// depends on iso_dv_pkg and the iso_date_string_validator rtl
module tb;
  import iso_dv_pkg::*;

  localparam int ITEM_GOAL   = 1200;
  localparam int CALM_AFTER  = 1050;
  localparam int QUIET_LIMIT = 2000;

  // one byte of a planned string, with an optional hand-written verdict
  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       known;
    logic       verdict;
  } date_item_t;

  typedef struct packed {
    logic known;
    logic verdict;
  } known_verdict_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char_byte;
  logic       in_is_last;
  logic       out_valid;
  logic       out_ready;
  logic       out_date_valid;

  // parse state of the local date model
  logic [3:0]  dp_pos   = '0;
  logic [13:0] dp_year  = '0;
  logic [6:0]  dp_month = '0;
  logic [6:0]  dp_day   = '0;
  logic        dp_good  = 1'b1;

  logic           verdict_q[$];
  known_verdict_t known_q[$];
  date_item_t     plan_q[$];

  int fail_count = 0;
  int items_sent = 0;
  int gap_pct    = 0;
  int stall_pct  = 0;
  int quiet_cycles = 0;

  logic           mon_done;
  logic           mon_ok;
  logic           mon_want;
  known_verdict_t mon_known;

  iso_date_string_validator uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_byte   (in_char_byte),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_date_valid (out_date_valid)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model: consume one byte, give the verdict when the string ends
  task automatic take_date_char(input logic [7:0] ch, input logic last,
                                output logic done, output logic ok);
    int   mlen;
    logic leap;
    done = 1'b0;
    ok   = 1'b0;
    if (dp_pos >= DATE_LEN) begin
      dp_good = 1'b0;
    end else if (dp_pos == POS_HYPHEN1 || dp_pos == POS_HYPHEN2) begin
      if (ch != CH_HYPHEN) dp_good = 1'b0;
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      if (dp_pos < POS_HYPHEN1) dp_year = dp_year * 14'd10 + 14'(ch - CH_ZERO);
      else if (dp_pos < POS_HYPHEN2) dp_month = dp_month * 7'd10 + 7'(ch - CH_ZERO);
      else dp_day = dp_day * 7'd10 + 7'(ch - CH_ZERO);
    end else begin
      dp_good = 1'b0;
    end
    dp_pos = (dp_pos >= POS_SAT) ? POS_SAT : dp_pos + 4'd1;
    if (last) begin
      leap = ((dp_year % 4 == 0) && (dp_year % 100 != 0)) || (dp_year % 400 == 0);
      case (dp_month)
        1, 3, 5, 7, 8, 10, 12: mlen = 31;
        4, 6, 9, 11:           mlen = 30;
        MONTH_FEB:             mlen = leap ? 29 : 28;
        default:               mlen = 0;
      endcase
      ok = dp_good && dp_pos == DATE_LEN && dp_year >= YEAR_MIN && dp_year <= YEAR_MAX &&
           dp_month >= 1 && dp_month <= 12 && dp_day >= 1 && dp_day <= mlen;
      done     = 1'b1;
      dp_pos   = '0;
      dp_year  = '0;
      dp_month = '0;
      dp_day   = '0;
      dp_good  = 1'b1;
    end
  endtask

  // scoreboard: check verdicts, then predict from accepted bytes
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result item: date_valid actual %0b", out_date_valid);
          fail_count++;
        end else begin
          mon_want = verdict_q.pop_front();
          if (out_date_valid !== mon_want) begin
            $error("date_valid mismatch: expected %0b, actual %0b", mon_want, out_date_valid);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        take_date_char(in_char_byte, in_is_last, mon_done, mon_ok);
        mon_known = known_q.pop_front();
        if (mon_done)
          verdict_q.insert(verdict_q.size(), mon_known.known ? mon_known.verdict : mon_ok);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side back-pressure in bursts
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // offer one item and hold it until accepted
  task automatic send_char(input date_item_t it);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    known_q.insert(known_q.size(), known_verdict_t'{known: it.known, verdict: it.verdict});
    in_valid     <= 1'b1;
    in_char_byte <= it.ch;
    in_is_last   <= it.last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic text_rows(input string s, input logic known, input logic verdict);
    int i;
    for (i = 0; i < s.len(); i++)
      plan_q.insert(plan_q.size(), date_item_t'{ch: s[i], last: (i == s.len() - 1),
                                                known: known, verdict: verdict});
  endtask

  task automatic run_plan();
    int i;
    for (i = 0; i < plan_q.size(); i++) send_char(plan_q[i]);
    plan_q.delete();
  endtask

  // hold the input off until every verdict is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (verdict_q.size() != 0);
    @(posedge clk);
  endtask

  // random string: mostly well-formed dates, some damaged, some noise
  task automatic plan_random_string();
    int         kind;
    int         year;
    int         month;
    int         day;
    int         n;
    int         i;
    string      s;
    logic [7:0] txt[$];
    int         near_years[10] = '{0, 1969, 1970, 1971, 1900, 2000, 2100, 2400, 9996, 9999};
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      case ($urandom_range(0, 3))
        0: year = $urandom_range(1970, 9999);
        1: year = near_years[$urandom_range(0, 9)];
        2: year = $urandom_range(0, 9999);
        default: year = $urandom_range(1970, 2100);
      endcase
      month = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0: day = $urandom_range(0, 99);
        1: day = $urandom_range(27, 32);
        default: day = $urandom_range(1, 31);
      endcase
      s = $sformatf("%04d-%02d-%02d", year, month, day);
      for (i = 0; i < s.len(); i++) txt.insert(txt.size(), s[i]);
      // damage: one wrong byte, cut short or run long
      if ($urandom_range(0, 99) < 12) txt[$urandom_range(0, 9)] = 8'($urandom_range(0, 255));
      n = $urandom_range(0, 99);
      if (n < 6) begin
        txt = txt[0:$urandom_range(0, 8)];
      end else if (n < 12) begin
        repeat ($urandom_range(1, 4)) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
      end
    end else begin
      n = $urandom_range(1, 14);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 1) != 0) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
        else txt.insert(txt.size(), 8'(CH_ZERO + $urandom_range(0, 9)));
      end
    end
    for (i = 0; i < txt.size(); i++)
      plan_q.insert(plan_q.size(), date_item_t'{ch: txt[i], last: (i == txt.size() - 1),
                                                known: 1'b0, verdict: 1'b0});
  endtask

  // main sequence
  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_char_byte <= '0;
    in_is_last   <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: top date, lone bad byte, leap century, bad byte in short string
    text_rows("9999-12-31", 1'b1, 1'b1);
    plan_q.insert(plan_q.size(), date_item_t'{ch: 8'hFF, last: 1'b1, known: 1'b1,
                                              verdict: 1'b0});
    text_rows("2000-02-29", 1'b0, 1'b0);
    text_rows("0:", 1'b1, 1'b0);
    run_plan();
    drain_results();

    // random strings with bursty idling on both sides, calm at the end
    while (items_sent < ITEM_GOAL) begin
      if (items_sent < CALM_AFTER) begin
        gap_pct   = 15 * $urandom_range(0, 3);
        stall_pct = 15 * $urandom_range(0, 3);
      end else begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      plan_random_string();
      run_plan();
      if ($urandom_range(0, 29) == 0) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
